// ===== rtl/hci_pkg.sv =====
// ----------------------------------------------------------------------------
// hci_pkg: shared definitions for the color interpolator
// Fixed-point constants, register indexes and the elaboration-time root table.
// ----------------------------------------------------------------------------
package hci_pkg;

  // Default fraction width of r, hue, saturation and brightness.
  localparam int DEF_FRAC_BITS = 16;

  // Fraction bits of a log2 value and of a normalized mantissa.
  localparam int LGF  = 28;
  localparam int MANB = 30;
  localparam int MW   = MANB + 1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LOG_BRIGHTNESS  = 2'd0;
  localparam logic [1:0] CFG_BRIGHTNESS_BIAS = 2'd1;
  localparam logic [1:0] CFG_SATURATION_BIAS = 2'd2;

  // Reset value of both biases: 0.010 in Q0.16.
  localparam logic [15:0] BIAS_RESET = 16'd655;

  // Truncating integer square root of a 64-bit value.
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = x;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(2^-k) in Q.30, built by k truncating square roots starting from 2.
  function automatic logic [31:0] root_factor(input int k);
    logic [63:0] s;
    s = 64'd2 << MANB;
    for (int i = 0; i < k; i++) begin
      s = isqrt64(s << MANB);
    end
    return s[31:0];
  endfunction

endpackage

// ===== rtl/hci_log_cell.sv =====
// ----------------------------------------------------------------------------
// hci_log_cell: one fraction bit of log2
// Square the normalized mantissa, emit one bit, renormalize, hand on.
// ----------------------------------------------------------------------------
module hci_log_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [hci_pkg::MW-1:0]    m_i,
  input  logic [hci_pkg::LGF-1:0]   fr_i,
  output logic [hci_pkg::MW-1:0]    m_o,
  output logic [hci_pkg::LGF-1:0]   fr_o
);

  logic [2*hci_pkg::MW-1:0] sq;
  logic [hci_pkg::MW:0]     top;
  logic [hci_pkg::MW-1:0]   m_d, m_q;
  logic [hci_pkg::LGF-1:0]  fr_d, fr_q;

  always_comb begin
    sq  = m_i * m_i;
    top = sq[2*hci_pkg::MW-1:hci_pkg::MANB];
    if (top[hci_pkg::MW]) begin
      m_d  = top[hci_pkg::MW:1];
      fr_d = {fr_i[hci_pkg::LGF-2:0], 1'b1};
    end else begin
      m_d  = top[hci_pkg::MW-1:0];
      fr_d = {fr_i[hci_pkg::LGF-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q  <= m_d;
      fr_q <= fr_d;
    end
  end

  assign m_o  = m_q;
  assign fr_o = fr_q;

endmodule

// ===== rtl/hci_exp_cell.sv =====
// ----------------------------------------------------------------------------
// hci_exp_cell: one fraction bit of exp2
// Multiply the mantissa by 2^(2^-K) when fraction bit K is set, hand on.
// ----------------------------------------------------------------------------
module hci_exp_cell #(
  parameter int K = 1
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [hci_pkg::MW-1:0]    pm_i,
  input  logic [hci_pkg::LGF-1:0]   f_i,
  output logic [hci_pkg::MW-1:0]    pm_o,
  output logic [hci_pkg::LGF-1:0]   f_o
);

  localparam logic [31:0] FACTOR = hci_pkg::root_factor(K);

  logic [hci_pkg::MW+31:0]  prod;
  logic [hci_pkg::MW-1:0]   pm_d, pm_q;
  logic [hci_pkg::LGF-1:0]  f_q;

  always_comb begin
    prod = pm_i * FACTOR;
    if (f_i[hci_pkg::LGF-K]) begin
      pm_d = prod[hci_pkg::MANB+hci_pkg::MW-1:hci_pkg::MANB];
    end else begin
      pm_d = pm_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pm_q <= pm_d;
      f_q  <= f_i;
    end
  end

  assign pm_o = pm_q;
  assign f_o  = f_q;

endmodule

// ===== rtl/hty_color_interpolator.sv =====
// ----------------------------------------------------------------------------
// hty_color_interpolator: hue/saturation/brightness color interpolation
// Pipelined interpolation with biased log scale for saturation and, when enabled, brightness.
// ----------------------------------------------------------------------------
// One color pair enters per clock and one result leaves per clock. With the
// 28-bit log fraction the pipe holds two entry stages (bias add, mantissa
// normalize), a row of 28 log2 cells that each square the mantissa
// once, a multiply stage and a rounding stage that mix the two logs with r, a
// row of 28 exp2 cells that each apply one constant root of two, and a final
// stage that rescales, removes the bias, clamps and selects the result. Four
// log lanes and two exp lanes run side by side, so brightness and saturation
// are handled together. The whole pipe advances when the output register is
// empty or being taken; s_axis_tready drops only while a result waits and the
// sink holds off. Write the configuration registers only while the pipe is
// empty: in-flight items see the current register values.
module hty_color_interpolator #(
  parameter int FRAC_BITS = hci_pkg::DEF_FRAC_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // frac, hue_a, sat_a, bright_a, hue_b, sat_b, bright_b (low bit up)
  input  logic [((7*FRAC_BITS+37+7)/8)*8-1:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hue_out, sat_out, bright_out, bad_input (low bit up)
  output logic [((3*FRAC_BITS+14+7)/8)*8-1:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i
);

  localparam int F     = FRAC_BITS;
  localparam int LGF   = hci_pkg::LGF;
  localparam int MANB  = hci_pkg::MANB;
  localparam int MW    = hci_pkg::MW;
  localparam int FW    = F + 1;
  localparam int HW    = F + 8;
  localparam int SW    = F + 5;
  localparam int SOW   = F + 4;
  localparam int BOW   = F + 1;
  localparam int XW    = F + 5;
  localparam int PW    = $clog2(XW);
  localparam int LW    = LGF + $clog2(F + 5) + 1;
  localparam int IPW   = LW - LGF;
  localparam int NW    = IPW + 2;
  localparam int GW    = F + 7;
  localparam int DW    = GW + 1;
  localparam int YLW   = F + 5;
  localparam int HPW   = FW + 1 + HW;
  localparam int YPW   = FW + SOW;
  localparam int PRW   = FW + 1 + LW;
  localparam int IN_W  = ((7*F+37+7)/8)*8;
  localparam int OUT_W = ((3*F+14+7)/8)*8;
  localparam int OUT_BITS = HW + SOW + BOW + 1;
  localparam int O_HA  = FW;
  localparam int O_SA  = O_HA + HW;
  localparam int O_BA  = O_SA + SW;
  localparam int O_HB  = O_BA + SW;
  localparam int O_SB  = O_HB + HW;
  localparam int O_BB  = O_SB + SW;
  localparam int BSL   = (F >= 16) ? F - 16 : 0;
  localparam int BSR   = (F < 16) ? 16 - F : 0;
  localparam int DEPTH = 2*LGF + 4;

  localparam logic [FW-1:0]  ONE     = {1'b1, {F{1'b0}}};
  localparam logic [SOW-1:0] SAT_MAX = {SOW{1'b1}};

  typedef struct packed {
    logic            bad;
    logic [FW-1:0]   r;
    logic [HW-1:0]   h_lin;
    logic [YLW-1:0]  y_lin;
    logic [PW-1:0]   pb0;
    logic [PW-1:0]   pb1;
    logic [PW-1:0]   ps0;
    logic [PW-1:0]   ps1;
    logic [XW-1:0]   gb_edge;
    logic [XW-1:0]   gs_edge;
    logic            b_exp;
    logic            s_exp;
    logic [IPW-1:0]  ipb;
    logic [IPW-1:0]  ips;
  } side_t;

  // Configuration registers
  logic        log_bright_q;
  logic [15:0] bright_bias_q, sat_bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_bright_q  <= 1'b0;
      bright_bias_q <= hci_pkg::BIAS_RESET;
      sat_bias_q    <= hci_pkg::BIAS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hci_pkg::CFG_LOG_BRIGHTNESS:  log_bright_q  <= cfg_wdata_i[0];
        hci_pkg::CFG_BRIGHTNESS_BIAS: bright_bias_q <= cfg_wdata_i;
        hci_pkg::CFG_SATURATION_BIAS: sat_bias_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Rescale biases from Q0.16 to Q.F
  logic [F+15:0] by_w, bs_w;
  logic [F-1:0]  by, bs;
  assign by_w = ({{F{1'b0}}, bright_bias_q} << BSL) >> BSR;
  assign bs_w = ({{F{1'b0}}, sat_bias_q} << BSL) >> BSR;
  assign by   = by_w[F-1:0];
  assign bs   = bs_w[F-1:0];

  // Global advance: move when the output register is free or being taken
  logic en;
  logic out_v_q;
  logic [DEPTH-1:0] v_q;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v_q     <= {v_q[DEPTH-2:0], s_axis_tvalid};
      out_v_q <= v_q[DEPTH-1];
    end
  end

  // ---------------- Entry stage: clamp r, check signs, add biases ----------
  logic [FW-1:0] in_frac, r_c;
  logic [HW-1:0] in_ha, in_hb, h0_c, h1_c;
  logic [SW-1:0] in_sa, in_ba, in_sb, in_bb;

  assign in_frac = s_axis_tdata[FW-1:0];
  assign in_ha   = s_axis_tdata[O_HA +: HW];
  assign in_sa   = s_axis_tdata[O_SA +: SW];
  assign in_ba   = s_axis_tdata[O_BA +: SW];
  assign in_hb   = s_axis_tdata[O_HB +: HW];
  assign in_sb   = s_axis_tdata[O_SB +: SW];
  assign in_bb   = s_axis_tdata[O_BB +: SW];

  // A gray endpoint takes the other endpoint's hue.
  assign r_c  = (in_frac > ONE) ? ONE : in_frac;
  assign h0_c = (in_sa == '0) ? in_hb : in_ha;
  assign h1_c = (in_sb == '0) ? h0_c : in_hb;

  logic            e0_bad_q;
  logic [FW-1:0]   e0_r_q;
  logic [HW-1:0]   e0_h0_q, e0_h1_q;
  logic [SOW-1:0]  e0_y0_q, e0_y1_q;
  logic [XW-1:0]   e0_x_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      e0_bad_q <= in_sa[SW-1] | in_ba[SW-1] | in_sb[SW-1] | in_bb[SW-1];
      e0_r_q   <= r_c;
      e0_h0_q  <= h0_c;
      e0_h1_q  <= h1_c;
      e0_y0_q  <= in_ba[SOW-1:0];
      e0_y1_q  <= in_bb[SOW-1:0];
      e0_x_q[0] <= XW'(in_ba[SOW-1:0]) + XW'(by);
      e0_x_q[1] <= XW'(in_bb[SOW-1:0]) + XW'(by);
      e0_x_q[2] <= XW'(in_sa[SOW-1:0]) + XW'(bs);
      e0_x_q[3] <= XW'(in_sb[SOW-1:0]) + XW'(bs);
    end
  end

  // ---------------- Normalize stage: mantissas, endpoints, linear products -
  function automatic logic [PW-1:0] msb_pos(input logic [XW-1:0] x);
    logic [PW-1:0] p;
    p = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) p = PW'(i);
    end
    return p;
  endfunction

  logic [FW-1:0]  r_inv0;
  logic [PW-1:0]  p_c [4];
  logic [MW-1:0]  m_c [4];
  logic [5:0]     sh_c [4];
  logic [XW-1:0]  gb_edge_c, gs_edge_c;
  logic           b_exp_c, s_exp_c;

  assign r_inv0 = ONE - e0_r_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      p_c[l]  = msb_pos(e0_x_q[l]);
      sh_c[l] = 6'(MANB) - 6'(p_c[l]);
      m_c[l]  = MW'(e0_x_q[l]) << sh_c[l];
    end
    // Exact endpoint cases of the biased geometric mean
    b_exp_c = 1'b0;
    priority if (e0_r_q == '0 || e0_x_q[0] == e0_x_q[1]) gb_edge_c = e0_x_q[0];
    else if (e0_r_q == ONE)                             gb_edge_c = e0_x_q[1];
    else if (e0_x_q[0] == '0 || e0_x_q[1] == '0)        gb_edge_c = '0;
    else begin
      gb_edge_c = '0;
      b_exp_c   = 1'b1;
    end
    s_exp_c = 1'b0;
    priority if (e0_r_q == '0 || e0_x_q[2] == e0_x_q[3]) gs_edge_c = e0_x_q[2];
    else if (e0_r_q == ONE)                             gs_edge_c = e0_x_q[3];
    else if (e0_x_q[2] == '0 || e0_x_q[3] == '0)        gs_edge_c = '0;
    else begin
      gs_edge_c = '0;
      s_exp_c   = 1'b1;
    end
  end

  logic                   e1_bad_q;
  logic [FW-1:0]          e1_r_q;
  logic signed [HPW-1:0]  e1_hp0_q, e1_hp1_q;
  logic [YPW-1:0]         e1_yp0_q, e1_yp1_q;
  logic [PW-1:0]          e1_p_q [4];
  logic [MW-1:0]          e1_m_q [4];
  logic [XW-1:0]          e1_gb_q, e1_gs_q;
  logic                   e1_bexp_q, e1_sexp_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_bad_q  <= e0_bad_q;
      e1_r_q    <= e0_r_q;
      e1_hp0_q  <= $signed({2'b00, r_inv0}) * $signed(e0_h0_q);
      e1_hp1_q  <= $signed({2'b00, e0_r_q}) * $signed(e0_h1_q);
      e1_yp0_q  <= r_inv0 * e0_y0_q;
      e1_yp1_q  <= e0_r_q * e0_y1_q;
      e1_p_q    <= p_c;
      e1_m_q    <= m_c;
      e1_gb_q   <= gb_edge_c;
      e1_gs_q   <= gs_edge_c;
      e1_bexp_q <= b_exp_c;
      e1_sexp_q <= s_exp_c;
    end
  end

  // Round linear hue and brightness, build the side record for the chain
  logic signed [HPW:0] h_sum;
  logic [YPW:0]        y_sum;
  side_t               side_c;

  always_comb begin
    h_sum = (HPW+1)'(e1_hp0_q) + (HPW+1)'(e1_hp1_q) + (HPW+1)'(ONE >> 1);
    y_sum = (YPW+1)'(e1_yp0_q) + (YPW+1)'(e1_yp1_q) + (YPW+1)'(ONE >> 1);
    side_c         = '0;
    side_c.bad     = e1_bad_q;
    side_c.r       = e1_r_q;
    side_c.h_lin   = HW'(h_sum >>> F);
    side_c.y_lin   = YLW'(y_sum >> F);
    side_c.pb0     = e1_p_q[0];
    side_c.pb1     = e1_p_q[1];
    side_c.ps0     = e1_p_q[2];
    side_c.ps1     = e1_p_q[3];
    side_c.gb_edge = e1_gb_q;
    side_c.gs_edge = e1_gs_q;
    side_c.b_exp   = e1_bexp_q;
    side_c.s_exp   = e1_sexp_q;
  end

  // ---------------- Log2 cells: four lanes, one fraction bit each ----------
  logic [MW-1:0]  lm  [4][LGF+1];
  logic [LGF-1:0] lfr [4][LGF+1];
  side_t          sl_q [LGF];

  for (genvar l = 0; l < 4; l++) begin : g_log_lane
    assign lm[l][0]  = e1_m_q[l];
    assign lfr[l][0] = '0;
    for (genvar j = 0; j < LGF; j++) begin : g_cell
      hci_log_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .m_i   (lm[l][j]),
        .fr_i  (lfr[l][j]),
        .m_o   (lm[l][j+1]),
        .fr_o  (lfr[l][j+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sl_q[0] <= side_c;
      for (int j = 1; j < LGF; j++) sl_q[j] <= sl_q[j-1];
    end
  end

  // ---------------- Mix stage: weight the logs by r --------------------------
  side_t                 sl_last;
  logic signed [LW-1:0]  lg [4];
  logic [PW-1:0]         lp [4];
  logic [FW-1:0]         r_m, r_inv_m;

  assign sl_last = sl_q[LGF-1];
  assign r_m     = sl_last.r;
  assign r_inv_m = ONE - r_m;
  assign lp[0]   = sl_last.pb0;
  assign lp[1]   = sl_last.pb1;
  assign lp[2]   = sl_last.ps0;
  assign lp[3]   = sl_last.ps1;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lg[l] = $signed({IPW'(lp[l]) - IPW'(F), lfr[l][LGF]});
    end
  end

  logic signed [PRW-1:0] mx_q [4];
  side_t                 mx_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q[0]   <= $signed({2'b00, r_inv_m}) * lg[0];
      mx_q[1]   <= $signed({2'b00, r_m}) * lg[1];
      mx_q[2]   <= $signed({2'b00, r_inv_m}) * lg[2];
      mx_q[3]   <= $signed({2'b00, r_m}) * lg[3];
      mx_side_q <= sl_last;
    end
  end

  // ---------------- Round stage: exponent split into integer and fraction ---
  logic signed [PRW:0] eb_sum, es_sum;
  logic [LW-1:0]       eb, es;
  side_t               rd_side_c;

  always_comb begin
    eb_sum = (PRW+1)'(mx_q[0]) + (PRW+1)'(mx_q[1]) + (PRW+1)'(ONE >> 1);
    es_sum = (PRW+1)'(mx_q[2]) + (PRW+1)'(mx_q[3]) + (PRW+1)'(ONE >> 1);
    eb     = LW'(eb_sum >>> F);
    es     = LW'(es_sum >>> F);
    rd_side_c     = mx_side_q;
    rd_side_c.ipb = eb[LW-1:LGF];
    rd_side_c.ips = es[LW-1:LGF];
  end

  logic [LGF-1:0] rd_f_q [2];
  side_t          rd_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_f_q[0] <= eb[LGF-1:0];
      rd_f_q[1] <= es[LGF-1:0];
      rd_side_q <= rd_side_c;
    end
  end

  // ---------------- Exp2 cells: two lanes, one root factor each ------------
  logic [MW-1:0]  xp [2][LGF+1];
  logic [LGF-1:0] xf [2][LGF+1];
  side_t          se_q [LGF];

  for (genvar l = 0; l < 2; l++) begin : g_exp_lane
    assign xp[l][0] = MW'(1) << MANB;
    assign xf[l][0] = rd_f_q[l];
    for (genvar k = 0; k < LGF; k++) begin : g_cell
      hci_exp_cell #(.K(k + 1)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .pm_i  (xp[l][k]),
        .f_i   (xf[l][k]),
        .pm_o  (xp[l][k+1]),
        .f_o   (xf[l][k+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      se_q[0] <= rd_side_q;
      for (int j = 1; j < LGF; j++) se_q[j] <= se_q[j-1];
    end
  end

  // ---------------- Final stage: rescale, remove bias, clamp, select --------
  side_t                fs;
  logic signed [NW-1:0] nb, ns;
  logic [4:0]           shb, shs;
  logic [31:0]          gb_w, gs_w;
  logic [GW-1:0]        gb, gs;
  logic signed [DW-1:0] y_sel, t_sel;
  logic [BOW-1:0]       y_c;
  logic [SOW-1:0]       t_c;
  logic [HW-1:0]        hue_d;
  logic [SOW-1:0]       sat_d;
  logic [BOW-1:0]       bright_d;
  logic                 bad_d;

  assign fs = se_q[LGF-1];

  always_comb begin
    nb   = NW'(MANB - F) - {{2{fs.ipb[IPW-1]}}, fs.ipb};
    ns   = NW'(MANB - F) - {{2{fs.ips[IPW-1]}}, fs.ips};
    shb  = nb[4:0];
    shs  = ns[4:0];
    gb_w = (32'(xp[0][LGF]) + (32'd1 << (shb - 5'd1))) >> shb;
    gs_w = (32'(xp[1][LGF]) + (32'd1 << (shs - 5'd1))) >> shs;
    gb   = fs.b_exp ? gb_w[GW-1:0] : GW'(fs.gb_edge);
    gs   = fs.s_exp ? gs_w[GW-1:0] : GW'(fs.gs_edge);

    if (log_bright_q) y_sel = $signed({1'b0, gb}) - $signed(DW'(by));
    else              y_sel = $signed(DW'(fs.y_lin));
    t_sel = $signed({1'b0, gs}) - $signed(DW'(bs));

    priority if (y_sel < 0)               y_c = '0;
    else if (y_sel > $signed(DW'(ONE)))   y_c = ONE;
    else                                  y_c = y_sel[BOW-1:0];

    priority if (t_sel < 0)                  t_c = '0;
    else if (t_sel > $signed(DW'(SAT_MAX)))  t_c = SAT_MAX;
    else                                     t_c = t_sel[SOW-1:0];

    bad_d    = fs.bad;
    priority if (fs.bad || y_c == '0) begin
      hue_d    = '0;
      sat_d    = '0;
      bright_d = '0;
    end else if (y_c == ONE) begin
      hue_d    = HW'(ONE);
      sat_d    = SOW'(ONE);
      bright_d = ONE;
    end else begin
      hue_d    = fs.h_lin;
      sat_d    = t_c;
      bright_d = y_c;
    end
  end

  logic [HW-1:0]  hue_q;
  logic [SOW-1:0] sat_q;
  logic [BOW-1:0] bright_q;
  logic           bad_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= bright_d;
      bad_q    <= bad_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, bad_q, bright_q, sat_q, hue_q};

endmodule

// ===== rtl/hci_checker.sv =====
// ----------------------------------------------------------------------------
// hci_checker: port-level checks for the color interpolator
// Watches the stream ports and the result fields over time.
// ----------------------------------------------------------------------------
module hci_checker #(
  parameter int FRAC_BITS = hci_pkg::DEF_FRAC_BITS
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((3*FRAC_BITS+14+7)/8)*8-1:0] m_axis_tdata
);

  localparam int HW  = FRAC_BITS + 8;
  localparam int SOW = FRAC_BITS + 4;
  localparam int BOW = FRAC_BITS + 1;
  localparam int O_B = HW + SOW;
  localparam int O_X = O_B + BOW;
  localparam logic [BOW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [HW-1:0]  hue;
  logic [SOW-1:0] sat;
  logic [BOW-1:0] bright;
  logic           bad;

  assign hue    = m_axis_tdata[HW-1:0];
  assign sat    = m_axis_tdata[HW +: SOW];
  assign bright = m_axis_tdata[O_B +: BOW];
  assign bad    = m_axis_tdata[O_X];

  // A held result blocks the pipe, so no new input may be taken.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && bad) |-> (hue == '0 && sat == '0 && bright == '0))
    else $error("bad input result not zero");

  a_bright_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (bright <= ONE))
    else $error("brightness above one");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && bright == '0) |-> (hue == '0 && sat == '0))
    else $error("black result with nonzero hue or saturation");

endmodule

bind hty_color_interpolator hci_checker #(.FRAC_BITS(FRAC_BITS)) u_hci_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
